FILE: rtl/core/otss_pkg.sv
// package for the occupancy template sad score block
// holds item codes, cell classes, state and register encodings, widths and reset values
// no dependencies
`timescale 1ns / 1ps

package otss_pkg;

	localparam int GRID_CELLS_DEF       = 65536;
	localparam int TEMPLATE_DEPTH_DEF   = 256;
	localparam int SINE_TABLE_DEPTH_DEF = 1024;

	localparam int WEIGHT_W = 9;
	localparam int TPL_W    = 16 + 16 + WEIGHT_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;

	localparam logic [6:0]  THR_RST   = 7'd65;
	localparam logic [31:0] ORIGX_RST = 32'd0;
	localparam logic [31:0] ORIGY_RST = 32'd0;
	localparam logic [15:0] OCOS_RST  = 16'd16384;
	localparam logic [15:0] OSIN_RST  = 16'd0;
	localparam logic [15:0] CPM_RST   = 16'd2560;
	localparam logic [8:0]  MW_RST    = 9'd256;
	localparam logic [8:0]  MH_RST    = 9'd256;

	localparam longint PI_HALF_Q30 = 64'sd1686629713;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_MAP   = 2'd2,
		OP_SCORE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CELL_UNKNOWN  = 2'd0,
		CELL_FREE     = 2'd1,
		CELL_OCCUPIED = 2'd2
	} cell_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef enum logic [2:0] {
		REG_THR   = 3'd0,
		REG_ORIGX = 3'd1,
		REG_ORIGY = 3'd2,
		REG_OCOS  = 3'd3,
		REG_OSIN  = 3'd4,
		REG_CPM   = 3'd5,
		REG_MW    = 3'd6,
		REG_MH    = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TRIG,
		ST_QUAD,
		ST_WALK,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/core/occupancy_template_sad_score.sv
// Scores a candidate pose against a stored occupancy grid. After reset the grid memory is
// swept to unknown, one cell a cycle; no item is taken meanwhile (configuration writes
// are). Clear, add and map-write items are taken whenever the block is idle. A pose item
// goes through trig and quadrant setup, the cell pipeline (one template read and one grid
// read per cycle, grid memory port bound), bit-serial division of the scaled sum and a
// result load; no item is taken until the result is loaded. An empty template goes
// straight to the result with no_observations set.
// depends on otss_pkg
`timescale 1ns / 1ps

module occupancy_template_sad_score
	import otss_pkg::*;
#(
	parameter int GRID_CELLS       = GRID_CELLS_DEF,
	parameter int TEMPLATE_DEPTH   = TEMPLATE_DEPTH_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             op,
	input  logic [15:0]            grid_addr,
	input  logic signed [7:0]      map_value,
	input  logic signed [15:0]     cell_x,
	input  logic signed [15:0]     cell_y,
	input  logic [WEIGHT_W-1:0]    cell_weight,
	input  logic signed [31:0]     pose_x,
	input  logic signed [31:0]     pose_y,
	input  logic [15:0]            pose_yaw,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [15:0]            sad_score,
	output logic                   no_observations,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int GAW    = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
	localparam int LIN_W  = 18;
	localparam int CMP_W  = (GAW + 1 > LIN_W) ? GAW + 1 : LIN_W;
	localparam int TAW    = (TEMPLATE_DEPTH > 1) ? $clog2(TEMPLATE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TEMPLATE_DEPTH + 1);
	localparam int SUM_W  = $clog2(256 * TEMPLATE_DEPTH + 1);
	localparam int DIV_W  = SUM_W + 8;
	localparam int DCNT_W = $clog2(DIV_W + 1);
	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int YP_W   = 14 + IDX_W;

	typedef logic [14:0] sine_rom_t [SINE_TABLE_DEPTH+1];

	function automatic sine_rom_t build_sine();
		sine_rom_t t;
		longint x;
		longint term;
		longint sum;
		longint r;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			if (i == SINE_TABLE_DEPTH) begin
				t[i] = 15'd16384;
			end else begin
				x = (PI_HALF_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
				term = x;
				sum = x;
				term = (term * x) >>> 30;
				term = (term * x) >>> 30;
				term = term / 6;
				sum = sum - term;
				term = (term * x) >>> 30;
				term = (term * x) >>> 30;
				term = term / 20;
				sum = sum + term;
				term = (term * x) >>> 30;
				term = (term * x) >>> 30;
				term = term / 42;
				sum = sum - term;
				term = (term * x) >>> 30;
				term = (term * x) >>> 30;
				term = term / 72;
				sum = sum + term;
				term = (term * x) >>> 30;
				term = (term * x) >>> 30;
				term = term / 110;
				sum = sum - term;
				r = (sum * 16384 + (64'sd1 <<< 29)) >>> 30;
				if (r > 16384) begin
					r = 16384;
				end
				if (r < 0) begin
					r = 0;
				end
				t[i] = 15'(r);
			end
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

	// configuration
	logic [6:0]         thr_q;
	logic signed [31:0] ox_q, oy_q;
	logic signed [15:0] ocos_q, osin_q;
	logic [15:0]        cpm_q;
	logic [8:0]         mw_q, mh_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RST;
			ox_q   <= ORIGX_RST;
			oy_q   <= ORIGY_RST;
			ocos_q <= OCOS_RST;
			osin_q <= OSIN_RST;
			cpm_q  <= CPM_RST;
			mw_q   <= MW_RST;
			mh_q   <= MH_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_THR:   thr_q  <= cfg_data[6:0];
				REG_ORIGX: ox_q   <= cfg_data;
				REG_ORIGY: oy_q   <= cfg_data;
				REG_OCOS:  ocos_q <= cfg_data[15:0];
				REG_OSIN:  osin_q <= cfg_data[15:0];
				REG_CPM:   cpm_q  <= cfg_data[15:0];
				REG_MW:    mw_q   <= cfg_data[8:0];
				REG_MH:    mh_q   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// control
	state_t state_q, state_d;
	logic [GAW-1:0]    clr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  k_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [SUM_W-1:0]  acc_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [CNT_W:0]    rem_q;
	logic              flag_q;
	logic              out_valid_q;
	logic [15:0]       score_q;
	logic              nobs_q;

	logic in_acc, clr_last, issue, issue_done, pipe_busy, div_last, load_out;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	assign in_acc     = in_valid && !in_stall;
	assign clr_last   = clr_q == GAW'(GRID_CELLS - 1);
	assign issue_done = k_q == cnt_q;
	assign pipe_busy  = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6 | v_s7 | v_s8 | v_s9;
	assign div_last   = dcnt_q == DCNT_W'(DIV_W - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_last) begin
				state_d = ST_IDLE;
			end
			ST_IDLE: if (in_acc && op_t'(op) == OP_SCORE) begin
				state_d = (cnt_q == '0) ? ST_DONE : ST_TRIG;
			end
			ST_TRIG: state_d = ST_QUAD;
			ST_QUAD: state_d = ST_WALK;
			ST_WALK: if (issue_done && !pipe_busy) begin
				state_d = ST_DIV;
			end
			ST_DIV: if (div_last) begin
				state_d = ST_DONE;
			end
			ST_DONE: if (!out_valid_q || !out_stall) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_WALK: issue = !issue_done;
			ST_DONE: load_out = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// template memory and count
	logic [TPL_W-1:0]    tpl_mem [TEMPLATE_DEPTH];
	logic [WEIGHT_W-1:0] w_in;
	logic                tpl_we;

	assign w_in   = (cell_weight > WEIGHT_FULL) ? WEIGHT_FULL : cell_weight;
	assign tpl_we = in_acc && op_t'(op) == OP_ADD && cnt_q < CNT_W'(TEMPLATE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && op_t'(op) == OP_CLEAR) begin
			cnt_q <= '0;
		end else if (tpl_we) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	logic signed [15:0]  tx_s1, ty_s1;
	logic [WEIGHT_W-1:0] tw_s1;

	always_ff @(posedge clk) begin
		if (tpl_we) begin
			tpl_mem[cnt_q[TAW-1:0]] <= {cell_x, cell_y, w_in};
		end
		{tx_s1, ty_s1, tw_s1} <= tpl_mem[k_q[TAW-1:0]];
	end

	// pose capture and trig
	logic signed [31:0] px_q, py_q;
	logic [15:0]        yaw_q;
	logic [YP_W-1:0]    yprod;
	logic [IDX_W-1:0]   idx_a, idx_b;
	logic [14:0]        rom_a_q, rom_b_q;
	logic signed [15:0] sa, sb, ys_q, yc_q;

	assign yprod = YP_W'(yaw_q[13:0]) * YP_W'(SINE_TABLE_DEPTH);
	assign idx_a = IDX_W'(yprod >> 14);
	assign idx_b = IDX_W'(SINE_TABLE_DEPTH) - idx_a;
	assign sa    = $signed({1'b0, rom_a_q});
	assign sb    = $signed({1'b0, rom_b_q});

	always_ff @(posedge clk) begin
		if (in_acc && op_t'(op) == OP_SCORE) begin
			px_q  <= pose_x;
			py_q  <= pose_y;
			yaw_q <= pose_yaw;
		end
		rom_a_q <= SINE_ROM[idx_a];
		rom_b_q <= SINE_ROM[idx_b];
		if (state_q == ST_QUAD) begin
			case (quad_t'(yaw_q[15:14]))
				QUAD_0: begin
					ys_q <= sa;
					yc_q <= sb;
				end
				QUAD_1: begin
					ys_q <= sb;
					yc_q <= -sa;
				end
				QUAD_2: begin
					ys_q <= -sa;
					yc_q <= -sb;
				end
				default: begin
					ys_q <= -sb;
					yc_q <= sa;
				end
			endcase
		end
	end

	// cell pipeline
	logic signed [31:0]  pcx_s2, psy_s2, psx_s2, pcy_s2;
	logic [WEIGHT_W-1:0] w_s2, w_s3, w_s4, w_s5, w_s6, w_s7, w_s8, w_s9;
	logic signed [32:0]  drx, dry;
	logic signed [18:0]  rx_s3, ry_s3;
	logic signed [33:0]  dx_s4, dy_s4;
	logic signed [49:0]  mcx_s5, msy_s5, mcy_s5, msx_s5;
	logic signed [50:0]  slx, sly;
	logic signed [36:0]  lx_s6, ly_s6;
	logic signed [53:0]  pcol, prow;
	logic signed [35:0]  col_s7, row_s7;
	logic                in_map;
	logic [LIN_W-1:0]    lin;
	logic                ok_s8, ok_s9;
	logic [GAW-1:0]      gaddr_s8;
	logic [1:0]          cls_s9;
	logic [WEIGHT_W-1:0] miss;

	assign drx = 33'(pcx_s2) - 33'(psy_s2) + 33'sd8192;
	assign dry = 33'(psx_s2) + 33'(pcy_s2) + 33'sd8192;
	assign slx = 51'(mcx_s5) + 51'(msy_s5) + 51'sd8192;
	assign sly = 51'(mcy_s5) - 51'(msx_s5) + 51'sd8192;
	assign pcol = lx_s6 * $signed({1'b0, cpm_q});
	assign prow = ly_s6 * $signed({1'b0, cpm_q});
	assign in_map = !col_s7[35] && (col_s7[34:0] < 35'(mw_q))
		&& !row_s7[35] && (row_s7[34:0] < 35'(mh_q));
	assign lin = LIN_W'(row_s7[8:0]) * LIN_W'(mw_q) + LIN_W'(col_s7[8:0]);

	always_ff @(posedge clk) begin
		pcx_s2 <= yc_q * tx_s1;
		psy_s2 <= ys_q * ty_s1;
		psx_s2 <= ys_q * tx_s1;
		pcy_s2 <= yc_q * ty_s1;
		w_s2   <= tw_s1;
		rx_s3  <= 19'(drx >>> 14);
		ry_s3  <= 19'(dry >>> 14);
		w_s3   <= w_s2;
		dx_s4  <= 34'(px_q) + 34'(rx_s3) - 34'(ox_q);
		dy_s4  <= 34'(py_q) + 34'(ry_s3) - 34'(oy_q);
		w_s4   <= w_s3;
		mcx_s5 <= ocos_q * dx_s4;
		msy_s5 <= osin_q * dy_s4;
		mcy_s5 <= ocos_q * dy_s4;
		msx_s5 <= osin_q * dx_s4;
		w_s5   <= w_s4;
		lx_s6  <= 37'(slx >>> 14);
		ly_s6  <= 37'(sly >>> 14);
		w_s6   <= w_s5;
		col_s7 <= 36'(pcol >>> 18);
		row_s7 <= 36'(prow >>> 18);
		w_s7   <= w_s6;
		ok_s8    <= in_map && (CMP_W'(lin) < CMP_W'(GRID_CELLS));
		gaddr_s8 <= GAW'(lin);
		w_s8     <= w_s7;
		ok_s9 <= ok_s8;
		w_s9  <= w_s8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			k_q  <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			if (state_q == ST_QUAD) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// grid memory
	logic [1:0] grid_mem [GRID_CELLS];
	logic       map_we;
	cell_t      cls_in;

	assign map_we = in_acc && op_t'(op) == OP_MAP
		&& (CMP_W'(grid_addr) < CMP_W'(GRID_CELLS));

	always_comb begin
		if (map_value == 8'sd0) begin
			cls_in = CELL_FREE;
		end else if (map_value >= $signed({1'b0, thr_q})) begin
			cls_in = CELL_OCCUPIED;
		end else begin
			cls_in = CELL_UNKNOWN;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			grid_mem[clr_q] <= CELL_UNKNOWN;
		end else if (map_we) begin
			grid_mem[GAW'(grid_addr)] <= cls_in;
		end
		cls_s9 <= grid_mem[gaddr_s8];
	end

	always_comb begin
		if (!ok_s9) begin
			miss = WEIGHT_FULL;
		end else begin
			case (cell_t'(cls_s9))
				CELL_OCCUPIED: miss = WEIGHT_FULL - w_s9;
				CELL_FREE:     miss = w_s9;
				default:       miss = WEIGHT_FULL;
			endcase
		end
	end

	// accumulate and divide
	logic [CNT_W:0] rem_n;
	logic           ge;

	assign rem_n = {rem_q[CNT_W-1:0], dvd_q[DIV_W-1]};
	assign ge    = rem_n >= {1'b0, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			dcnt_q <= '0;
			flag_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					acc_q  <= '0;
					dvd_q  <= '0;
					flag_q <= 1'b1;
				end
				ST_WALK: begin
					if (v_s9) begin
						acc_q <= acc_q + SUM_W'(miss);
					end
					if (issue_done && !pipe_busy) begin
						dvd_q  <= {acc_q, 8'd0};
						rem_q  <= '0;
						dcnt_q <= '0;
						flag_q <= 1'b0;
					end
				end
				ST_DIV: begin
					rem_q  <= ge ? rem_n - {1'b0, cnt_q} : rem_n;
					dvd_q  <= {dvd_q[DIV_W-2:0], ge};
					dcnt_q <= dcnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			score_q <= (dvd_q > DIV_W'(16'hFFFF)) ? 16'hFFFF : dvd_q[15:0];
			nobs_q  <= flag_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign sad_score       = score_q;
	assign no_observations = nobs_q;

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> k_q <= cnt_q)
		else $error("template walk ran past the loaded count");

	a_pipe_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 |-> state_q == ST_WALK)
		else $error("cell pipeline active outside a pose walk");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TEMPLATE_DEPTH))
		else $error("template count beyond depth");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < {1'b0, cnt_q})
		else $error("divider remainder not below divisor");

	a_no_item_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> in_stall && !out_valid_q)
		else $error("item traffic during grid sweep");

endmodule

FILE: tb/sv/tb_occupancy_template_sad_score.sv
// testbench for occupancy_template_sad_score: directed, full template, configuration sweep, pressure and random items
// predicts each pose score with its own grid, template and sine table, checked in order
// depends on otss_pkg and the rtl of occupancy_template_sad_score
`timescale 1ns / 1ps

module tb_occupancy_template_sad_score;
	import otss_pkg::*;

	localparam int LIMIT = 4000000;
	localparam int DRAIN = 400;

	typedef struct {
		op_t                op;
		logic [15:0]        idx;
		logic signed [7:0]  val;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [8:0]         w;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [15:0]        yaw;
	} item_t;

	typedef struct {
		logic [15:0] score;
		logic        empty;
	} score_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] op = '0;
	logic [15:0] grid_addr = '0;
	logic signed [7:0] map_value = '0;
	logic signed [15:0] cell_x = '0;
	logic signed [15:0] cell_y = '0;
	logic [8:0] cell_weight = '0;
	logic signed [31:0] pose_x = '0;
	logic signed [31:0] pose_y = '0;
	logic [15:0] pose_yaw = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [15:0] sad_score;
	logic no_observations;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	occupancy_template_sad_score dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	cell_t  grid [0:65535];
	int     tpl_x [0:255];
	int     tpl_y [0:255];
	int     tpl_w [0:255];
	int     tpl_count;
	longint sine_q14 [0:1024];
	int     thr;
	longint org_x, org_y, org_cos, org_sin, cpm, map_w, map_h;

	score_t scores_due [$];
	int     errors = 0;
	int     cycles = 0;
	int     n_sent = 0;
	bit     calm = 0;
	bit     hold_req = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic longint quarter_sine_q14(int i);
		longint x, term, sum, r;
		if (i >= 1024)
			return 16384;
		x = (PI_HALF_Q30 * i) / 1024;
		term = x;
		sum = x;
		for (int k = 1; k <= 5; k++) begin
			term = (term * x) >>> 30;
			term = (term * x) >>> 30;
			term = term / ((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				sum -= term;
			else
				sum += term;
		end
		r = (sum * 16384 + (64'sd1 <<< 29)) >>> 30;
		if (r > 16384)
			r = 16384;
		if (r < 0)
			r = 0;
		return r;
	endfunction

	function automatic longint round_q(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	task automatic reset_model();
		for (int i = 0; i < 65536; i++)
			grid[i] = CELL_UNKNOWN;
		for (int i = 0; i <= 1024; i++)
			sine_q14[i] = quarter_sine_q14(i);
		tpl_count = 0;
		thr = 65;
		org_x = 0;
		org_y = 0;
		org_cos = 16384;
		org_sin = 0;
		cpm = 2560;
		map_w = 256;
		map_h = 256;
	endtask

	task automatic predict_item(item_t it);
		longint ys, yc, a, b, wx, wy, dx, dy, lx, ly, col, row, addr;
		longint sum, score;
		int miss, idx;
		score_t res;
		case (it.op)
			OP_CLEAR: tpl_count = 0;
			OP_ADD: if (tpl_count < 256) begin
				tpl_x[tpl_count] = it.cx;
				tpl_y[tpl_count] = it.cy;
				tpl_w[tpl_count] = (it.w > 256) ? 256 : int'(it.w);
				tpl_count++;
			end
			OP_MAP: begin
				if (it.val == 0)
					grid[it.idx] = CELL_FREE;
				else if (int'(it.val) >= thr)
					grid[it.idx] = CELL_OCCUPIED;
				else
					grid[it.idx] = CELL_UNKNOWN;
			end
			default: begin
				if (tpl_count == 0) begin
					res.score = '0;
					res.empty = 1'b1;
				end else begin
					idx = it.yaw[13:4];
					a = sine_q14[idx];
					b = sine_q14[1024 - idx];
					case (quad_t'(it.yaw[15:14]))
						QUAD_0: begin ys = a;  yc = b;  end
						QUAD_1: begin ys = b;  yc = -a; end
						QUAD_2: begin ys = -a; yc = -b; end
						default: begin ys = -b; yc = a; end
					endcase
					sum = 0;
					for (int k = 0; k < tpl_count; k++) begin
						wx = it.px + round_q(yc * tpl_x[k] - ys * tpl_y[k], 14);
						wy = it.py + round_q(ys * tpl_x[k] + yc * tpl_y[k], 14);
						dx = wx - org_x;
						dy = wy - org_y;
						lx = round_q(org_cos * dx + org_sin * dy, 14);
						ly = round_q(org_cos * dy - org_sin * dx, 14);
						col = (lx * cpm) >>> 18;
						row = (ly * cpm) >>> 18;
						miss = 256;
						if (col >= 0 && col < map_w && row >= 0 && row < map_h) begin
							addr = row * map_w + col;
							if (addr < 65536) begin
								if (grid[addr] == CELL_OCCUPIED)
									miss = 256 - tpl_w[k];
								else if (grid[addr] == CELL_FREE)
									miss = tpl_w[k];
							end
						end
						sum += miss;
					end
					score = (sum * 256) / tpl_count;
					res.score = (score > 65535) ? 16'hFFFF : score[15:0];
					res.empty = 1'b0;
				end
				scores_due.push_back(res);
			end
		endcase
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		score_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (scores_due.size() == 0) begin
				report("unexpected result", sad_score, -1);
			end else begin
				want = scores_due.pop_front();
				if (sad_score !== want.score)
					report("sad_score", sad_score, want.score);
				if (no_observations !== want.empty)
					report("no_observations", no_observations, want.empty);
			end
		end
	end

	// receiver
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				repeat (900) @(negedge clk) out_stall <= 1'b1;
				hold_req = 0;
			end
			n = calm ? 0 : $urandom_range(0, 13);
			repeat (n) @(negedge clk) out_stall <= 1'b1;
			@(negedge clk) out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall) && !hold_req);
		end
	end

	task automatic send_item(item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		repeat (gap) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid <= 1'b1;
		op <= it.op;
		grid_addr <= it.idx;
		map_value <= it.val;
		cell_x <= it.cx;
		cell_y <= it.cy;
		cell_weight <= it.w;
		pose_x <= it.px;
		pose_y <= it.py;
		pose_yaw <= it.yaw;
		do @(posedge clk); while (in_stall);
		predict_item(it);
		n_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk) in_valid <= 1'b0;
		while (scores_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [31:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			REG_THR:   thr = d[6:0];
			REG_ORIGX: org_x = $signed(d);
			REG_ORIGY: org_y = $signed(d);
			REG_OCOS:  org_cos = $signed(d[15:0]);
			REG_OSIN:  org_sin = $signed(d[15:0]);
			REG_CPM:   cpm = d[15:0];
			REG_MW:    map_w = d[8:0];
			default:   map_h = d[8:0];
		endcase
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	function automatic item_t any_item();
		item_t it;
		it.op = op_t'($urandom_range(0, 3));
		it.idx = 16'($urandom);
		it.val = 8'($urandom);
		it.cx = 16'($urandom);
		it.cy = 16'($urandom);
		it.w = 9'($urandom);
		it.px = $urandom;
		it.py = $urandom;
		it.yaw = 16'($urandom);
		return it;
	endfunction

	function automatic item_t mk(op_t o);
		item_t it;
		it = any_item();
		it.op = o;
		return it;
	endfunction

	// pose near the origin, so cells mostly land in the map
	function automatic item_t near_pose();
		item_t it;
		it = mk(OP_SCORE);
		it.px = 32'(org_x) + $urandom_range(0, 26000);
		it.py = 32'(org_y) + $urandom_range(0, 26000);
		return it;
	endfunction

	function automatic item_t near_cell();
		item_t it;
		it = mk(OP_ADD);
		it.cx = 16'($signed($urandom_range(0, 6000)) - 3000);
		it.cy = 16'($signed($urandom_range(0, 6000)) - 3000);
		it.w = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(257, 511)) : 9'($urandom_range(0, 256));
		return it;
	endfunction

	function automatic item_t map_write();
		item_t it;
		it = mk(OP_MAP);
		case ($urandom_range(0, 3))
			0: it.val = 8'sd0;
			1: it.val = 8'($urandom_range(60, 127));
			default: it.val = 8'($urandom);
		endcase
		return it;
	endfunction

	// one well-formed group: optional clear, template, map writes, poses
	task automatic send_group(int max_cells);
		int n;
		if ($urandom_range(0, 1))
			send_item(mk(OP_CLEAR));
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_cells) : $urandom_range(1, 6);
		repeat (n) send_item(near_cell());
		repeat ($urandom_range(2, 8)) send_item(map_write());
		repeat ($urandom_range(1, 3)) send_item(near_pose());
	endtask

	task automatic test_directed();
		item_t it;
		send_item(mk(OP_CLEAR));
		send_item(near_pose());
		foreach (grid[i]) begin
			if (i >= 12) break;
			it = mk(OP_MAP);
			it.idx = 16'(i * 257);
			it.val = (i % 4 == 0) ? 8'sd0 : (i % 4 == 1) ? -8'sd128 : (i % 4 == 2) ? 8'sd127 : 8'sd64;
			send_item(it);
		end
		it = mk(OP_MAP);
		it.idx = 16'hFFFF;
		it.val = 8'sd65;
		send_item(it);
		for (int i = 0; i < 4; i++) begin
			it = mk(OP_ADD);
			it.cx = (i[0]) ? 16'sh7FFF : 16'sh8000;
			it.cy = (i[1]) ? 16'sh7FFF : 16'sh8000;
			it.w = (i == 0) ? 9'd0 : (i == 1) ? 9'd256 : (i == 2) ? 9'd511 : 9'd128;
			send_item(it);
		end
		foreach (scores_due[i]);
		for (int i = 0; i < 5; i++) begin
			it = near_pose();
			it.yaw = (i == 4) ? 16'hFFFF : 16'(i * 16384);
			send_item(it);
		end
		it = mk(OP_SCORE);
		it.px = 32'sh7FFFFFFF;
		it.py = 32'sh80000000;
		send_item(it);
		wait_drained();
	endtask

	task automatic test_template_full();
		send_item(mk(OP_CLEAR));
		repeat (258) send_item(near_cell());
		send_item(near_pose());
		send_item(near_pose());
		send_item(mk(OP_CLEAR));
		wait_drained();
	endtask

	task automatic test_config_sweep();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_THR, 0);
					write_reg(REG_CPM, 65535);
					write_reg(REG_MW, 1);
				end
				1: begin
					write_reg(REG_THR, 100);
					write_reg(REG_ORIGX, 32'h80000000);
					write_reg(REG_ORIGY, 32'h7FFFFFFF);
					write_reg(REG_OCOS, 32'hFFFFC000);
					write_reg(REG_CPM, 1);
					write_reg(REG_MW, 256);
					write_reg(REG_MH, 1);
				end
				2: begin
					write_reg(REG_THR, 50);
					write_reg(REG_ORIGX, 5000);
					write_reg(REG_ORIGY, -3000);
					write_reg(REG_OCOS, 0);
					write_reg(REG_OSIN, 16384);
					write_reg(REG_CPM, 2560);
					write_reg(REG_MW, 200);
					write_reg(REG_MH, 150);
				end
				3: begin
					write_reg(REG_OSIN, 32'hFFFFC000);
					write_reg(REG_CPM, 0);
					write_reg(REG_MW, 0);
					write_reg(REG_MH, 0);
				end
				default: begin
					write_reg(REG_THR, 65);
					write_reg(REG_ORIGX, 0);
					write_reg(REG_ORIGY, 0);
					write_reg(REG_OCOS, 11585);
					write_reg(REG_OSIN, -11585);
					write_reg(REG_CPM, 512);
					write_reg(REG_MW, 256);
					write_reg(REG_MH, 256);
				end
			endcase
			send_group(20);
			wait_drained();
		end
		write_reg(REG_OCOS, 16384);
		write_reg(REG_OSIN, 0);
		write_reg(REG_CPM, 2560);
	endtask

	task automatic test_pressure();
		send_item(mk(OP_CLEAR));
		repeat (20) send_item(near_cell());
		hold_req = 1;
		repeat (8) send_item(near_pose());
		wait_drained();
	endtask

	task automatic test_random();
		while (n_sent < 400) begin
			calm = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) < 8)
				send_group(60);
			else
				repeat (4) send_item(any_item());
		end
		calm = 0;
		wait_drained();
	endtask

	initial begin
		reset_model();
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_directed();
		test_template_full();
		test_config_sweep();
		test_pressure();
		test_random();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
